// ----- src/kl_divergence_accumulator_macros.svh -----
// Assertion macros for the divergence accumulator.
// Depends on nothing; files that check their own logic include it.
`ifndef KL_DIVERGENCE_ACCUMULATOR_MACROS_SVH
`define KL_DIVERGENCE_ACCUMULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define KLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KLD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define KLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/kld_pkg.sv -----
// Shared types, codes, constants and the log2 fraction table of the
// divergence accumulator. Depends on nothing.
`default_nettype none

package kld_pkg;

   localparam int LOG_TABLE_ENTRIES = 64;
   localparam int LOG_IDX_W = $clog2(LOG_TABLE_ENTRIES);
   localparam int LOG_ADDR_W = $clog2(LOG_TABLE_ENTRIES + 1);
   localparam int LOG_POS_W = 16 + LOG_IDX_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic signed [17:0] LN2_Q16 = 18'sd45426;
   localparam logic [23:0] THRESHOLD_RESET = 24'd6554;
   localparam logic signed [33:0] SUM_MAX = {1'b0, {33{1'b1}}};
   localparam logic signed [33:0] SUM_MIN = {1'b1, {33{1'b0}}};

   localparam logic [1:0] KIND_SKIP = 2'd0;
   localparam logic [1:0] KIND_ZERO_Q = 2'd1;
   localparam logic [1:0] KIND_TERM = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_OVER = 2'd1;
   localparam logic [1:0] STATUS_ZERO_Q = 2'd2;

   typedef struct packed {
      logic [16:0] prob_p;
      logic [16:0] prob_q;
      logic [1:0]  kind;
      logic        last;
   } item_type;

   typedef logic [16:0] log_table_type [0:LOG_TABLE_ENTRIES];

   // Entry i is log2(1 + i/N) in Q1.16, found by repeated squaring to 20 bits.
   function automatic log_table_type build_log_table();
      log_table_type t;
      logic [63:0] y;
      logic [19:0] r;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         y = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
         r = '0;
         for (int k = 0; k < 20; k++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30)) begin
               y = y >> 1;
               r[0] = 1'b1;
            end
         end
         t[i] = 17'((21'(r) + 21'd8) >> 4);
      end
      t[LOG_TABLE_ENTRIES] = ONE_Q16;
      return t;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

// ----- src/kl_divergence_accumulator.sv -----
// Top level of the divergence accumulator: threshold register and the
// front end, queue and back end. Depends on kld_pkg, kld_front, kld_queue, kld_back.
//
//   channel   ports                                   handshake
//   request   req_prob_p, req_prob_q, req_last_pair   req_push / req_full
//   response  rsp_divergence, rsp_status              rsp_pop / rsp_empty
//   csr       csr_wdata (divergence threshold)        csr_valid / csr_ready
//
// One request enters per cycle while req_full is low; the back end is a nine-stage
// pipeline from the queue head through log2 lookup, two multiplies, the accumulator
// and the result. A response passes the front register, the queue and these stages.
// Reset is synchronous and clears the sum, the error flag and all valid state.
// A waiting response stalls the back end; the four-entry queue lets requests
// keep arriving until it and the front register are full.
`default_nettype none
`include "kl_divergence_accumulator_macros.svh"

module kl_divergence_accumulator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [16:0] req_prob_p,
   input  wire logic [16:0] req_prob_q,
   input  wire logic        req_last_pair,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [23:0]      rsp_divergence,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [23:0] csr_wdata
);

   logic [23:0]       threshold_ff;
   logic              queue_full;
   logic              queue_empty;
   logic              queue_wr_valid;
   logic              queue_pop;
   kld_pkg::item_type queue_wr_item;
   kld_pkg::item_type queue_rd_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= kld_pkg::THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_wdata;
      end
   end

   kld_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_prob_p     (req_prob_p),
      .req_prob_q     (req_prob_q),
      .req_last_pair  (req_last_pair),
      .queue_full     (queue_full),
      .queue_wr_valid (queue_wr_valid),
      .queue_wr_item  (queue_wr_item)
   );

   kld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (queue_wr_valid),
      .wr_item  (queue_wr_item),
      .full     (queue_full),
      .rd_pop   (queue_pop),
      .rd_item  (queue_rd_item),
      .empty    (queue_empty)
   );

   kld_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_item     (queue_rd_item),
      .queue_pop      (queue_pop),
      .threshold      (threshold_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_divergence (rsp_divergence),
      .rsp_status     (rsp_status)
   );

   `KLD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, rsp_empty && !req_full,
      "reset left a request or response pending")
   `KLD_ASSERT_NOW(a_status_code, clock, reset, !rsp_empty,
      rsp_status == kld_pkg::STATUS_OK || rsp_status == kld_pkg::STATUS_OVER ||
      rsp_status == kld_pkg::STATUS_ZERO_Q, "undefined response status")
   `KLD_ASSERT_NOW(a_zero_on_fail, clock, reset, !rsp_empty && rsp_status != kld_pkg::STATUS_OK,
      rsp_divergence == '0, "failed response carries a nonzero divergence")

endmodule

`default_nettype wire

// ----- src/kld_front.sv -----
// Front end: takes a request, clamps both probabilities to one and
// classifies the pair. Depends on kld_pkg.
`default_nettype none

module kld_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [16:0]       req_prob_p,
   input  wire logic [16:0]       req_prob_q,
   input  wire logic              req_last_pair,
   input  wire logic              queue_full,
   output logic                   queue_wr_valid,
   output kld_pkg::item_type      queue_wr_item
);

   logic              front_valid_ff;
   logic              front_valid_in;
   kld_pkg::item_type front_item_ff;
   kld_pkg::item_type front_item_in;
   logic              accept;
   logic [16:0]       p_clamped;
   logic [16:0]       q_clamped;

   assign req_full = front_valid_ff && queue_full;
   assign accept = req_push && !req_full;
   assign queue_wr_valid = front_valid_ff && !queue_full;
   assign queue_wr_item = front_item_ff;

   always_comb begin
      p_clamped = (req_prob_p > kld_pkg::ONE_Q16) ? kld_pkg::ONE_Q16 : req_prob_p;
      q_clamped = (req_prob_q > kld_pkg::ONE_Q16) ? kld_pkg::ONE_Q16 : req_prob_q;
      front_item_in.prob_p = p_clamped;
      front_item_in.prob_q = q_clamped;
      front_item_in.last = req_last_pair;
      priority if (p_clamped == '0) begin
         front_item_in.kind = kld_pkg::KIND_SKIP;
      end else if (q_clamped == '0) begin
         front_item_in.kind = kld_pkg::KIND_ZERO_Q;
      end else begin
         front_item_in.kind = kld_pkg::KIND_TERM;
      end
      front_valid_in = accept || req_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/kld_queue.sv -----
// Short queue of classified requests between front and back end.
// Depends on kld_pkg.
`default_nettype none

module kld_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   input  kld_pkg::item_type      wr_item,
   output logic                   full,
   input  wire logic              rd_pop,
   output kld_pkg::item_type      rd_item,
   output logic                   empty
);

   kld_pkg::item_type                entry_ff [0:kld_pkg::QUEUE_DEPTH-1];
   logic [kld_pkg::QUEUE_IDX_W-1:0]  wr_ptr_ff;
   logic [kld_pkg::QUEUE_IDX_W-1:0]  wr_ptr_in;
   logic [kld_pkg::QUEUE_IDX_W-1:0]  rd_ptr_ff;
   logic [kld_pkg::QUEUE_IDX_W-1:0]  rd_ptr_in;
   logic [kld_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic [kld_pkg::QUEUE_CNT_W-1:0]  count_in;
   logic                             do_wr;
   logic                             do_rd;

   assign full = (count_ff == kld_pkg::QUEUE_CNT_W'(kld_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_valid && !full;
   assign do_rd = rd_pop && !empty;
   assign rd_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == kld_pkg::QUEUE_IDX_W'(kld_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == kld_pkg::QUEUE_IDX_W'(kld_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ----- src/kld_back.sv -----
// Back end: log2 of both probabilities, ln ratio, weighted term, saturating
// accumulation and the result register. Depends on kld_pkg.
`default_nettype none

module kld_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  kld_pkg::item_type      queue_item,
   output logic                   queue_pop,
   input  wire logic [23:0]       threshold,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [23:0]            rsp_divergence,
   output logic [1:0]             rsp_status
);

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       last;
   } tag_type;

   typedef struct packed {
      logic [4:0]  expo;
      logic [16:0] lo;
      logic [16:0] hi;
      logic [15:0] rem;
   } log_part_type;

   function automatic logic [4:0] lead_one(input logic [16:0] x);
      logic [4:0] e;
      e = '0;
      for (int i = 0; i < 17; i++) begin
         if (x[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

   function automatic log_part_type log_part(input logic [16:0] x);
      log_part_type                     r;
      logic [32:0]                      shifted;
      logic [15:0]                      frac;
      logic [kld_pkg::LOG_POS_W-1:0]    pos;
      logic [kld_pkg::LOG_IDX_W-1:0]    idx;
      r.expo = lead_one(x);
      shifted = 33'(x) << (5'd16 - r.expo);
      frac = shifted[15:0];
      pos = kld_pkg::LOG_POS_W'(frac) * kld_pkg::LOG_POS_W'(kld_pkg::LOG_TABLE_ENTRIES);
      idx = pos[kld_pkg::LOG_POS_W-1:16];
      r.rem = pos[15:0];
      r.lo = kld_pkg::LOG_TABLE[kld_pkg::LOG_ADDR_W'(idx)];
      r.hi = kld_pkg::LOG_TABLE[kld_pkg::LOG_ADDR_W'(idx) + 1'b1];
      return r;
   endfunction

   // Divide by 2^16 and round to nearest with ties away from zero.
   function automatic logic signed [23:0] round_shift16(input logic signed [39:0] v);
      logic        neg;
      logic [39:0] mag;
      logic [23:0] res;
      neg = v[39];
      mag = neg ? 40'(-v) : 40'(v);
      mag = (mag + 40'd32768) >> 16;
      res = mag[23:0];
      return neg ? $signed(-res) : $signed(res);
   endfunction

   logic                adv;

   tag_type             tag_lg_ff, tag_ip_ff, tag_df_ff, tag_m1_ff;
   tag_type             tag_ln_ff, tag_m2_ff, tag_tm_ff;
   tag_type             tag_lg_in;
   logic [16:0]         p_lg_ff, p_ip_ff, p_df_ff, p_m1_ff, p_ln_ff;
   log_part_type        part_p_ff, part_q_ff;
   logic [20:0]         base_p_ff, base_q_ff;
   logic [16:0]         interp_p_ff, interp_q_ff;
   logic [33:0]         interp_p_full, interp_q_full;
   logic [20:0]         log_p, log_q;
   logic signed [21:0]  diff_ff;
   logic signed [39:0]  prod_ln_ff;
   logic signed [21:0]  ln_ff;
   logic signed [23:0]  ln_round;
   logic signed [39:0]  prod_term_ff;
   logic signed [21:0]  term_ff;
   logic signed [23:0]  term_round;

   logic signed [33:0]  sum_ff, sum_in;
   logic                err_ff, err_in;
   logic signed [34:0]  sum_wide;
   logic signed [33:0]  sum_next;
   logic                err_next;
   logic                fin_valid_ff, fin_valid_in;
   logic signed [33:0]  fin_sum_ff, fin_sum_in;
   logic                fin_err_ff;

   logic                rsp_valid_ff;
   logic [23:0]         rsp_divergence_ff, rsp_divergence_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [33:0]         fin_mag;

   assign adv = !rsp_valid_ff || rsp_pop;
   assign queue_pop = adv && !queue_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_divergence = rsp_divergence_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      tag_lg_in.valid = !queue_empty;
      tag_lg_in.kind = queue_item.kind;
      tag_lg_in.last = queue_item.last;

      interp_p_full = 34'(part_p_ff.hi - part_p_ff.lo) * 34'(part_p_ff.rem) + 34'd32768;
      interp_q_full = 34'(part_q_ff.hi - part_q_ff.lo) * 34'(part_q_ff.rem) + 34'd32768;

      log_p = base_p_ff + 21'(interp_p_ff);
      log_q = base_q_ff + 21'(interp_q_ff);

      ln_round = round_shift16(prod_ln_ff);
      term_round = round_shift16(prod_term_ff);

      sum_wide = 35'(sum_ff) + 35'(term_ff);
      if (sum_wide[34] != sum_wide[33]) begin
         sum_next = sum_wide[34] ? kld_pkg::SUM_MIN : kld_pkg::SUM_MAX;
      end else begin
         sum_next = sum_wide[33:0];
      end

      sum_in = sum_ff;
      fin_sum_in = sum_ff;
      err_in = err_ff;
      err_next = err_ff;
      fin_valid_in = 1'b0;
      if (tag_tm_ff.valid) begin
         if (!err_ff) begin
            unique case (tag_tm_ff.kind)
               kld_pkg::KIND_TERM: begin
                  sum_in = sum_next;
                  fin_sum_in = sum_next;
               end
               kld_pkg::KIND_ZERO_Q: err_next = 1'b1;
               default:              sum_in = sum_ff;
            endcase
         end
         err_in = err_next;
         if (tag_tm_ff.last) begin
            fin_valid_in = 1'b1;
            sum_in = '0;
            err_in = 1'b0;
         end
      end

      fin_mag = fin_sum_ff[33] ? 34'(-fin_sum_ff) : 34'(fin_sum_ff);
      priority if (fin_err_ff) begin
         rsp_status_in = kld_pkg::STATUS_ZERO_Q;
         rsp_divergence_in = '0;
      end else if (fin_mag >= 34'(threshold)) begin
         rsp_status_in = kld_pkg::STATUS_OVER;
         rsp_divergence_in = '0;
      end else begin
         rsp_status_in = kld_pkg::STATUS_OK;
         rsp_divergence_in = fin_mag[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_lg_ff <= '0;
         tag_ip_ff <= '0;
         tag_df_ff <= '0;
         tag_m1_ff <= '0;
         tag_ln_ff <= '0;
         tag_m2_ff <= '0;
         tag_tm_ff <= '0;
         sum_ff <= '0;
         err_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         tag_lg_ff <= tag_lg_in;
         tag_ip_ff <= tag_lg_ff;
         tag_df_ff <= tag_ip_ff;
         tag_m1_ff <= tag_df_ff;
         tag_ln_ff <= tag_m1_ff;
         tag_m2_ff <= tag_ln_ff;
         tag_tm_ff <= tag_m2_ff;
         sum_ff <= sum_in;
         err_ff <= err_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= fin_valid_ff;
      end
      if (adv) begin
         p_lg_ff <= queue_item.prob_p;
         part_p_ff <= log_part(queue_item.prob_p);
         part_q_ff <= log_part(queue_item.prob_q);

         p_ip_ff <= p_lg_ff;
         base_p_ff <= {part_p_ff.expo, 16'd0} + 21'(part_p_ff.lo);
         base_q_ff <= {part_q_ff.expo, 16'd0} + 21'(part_q_ff.lo);
         interp_p_ff <= interp_p_full[32:16];
         interp_q_ff <= interp_q_full[32:16];

         p_df_ff <= p_ip_ff;
         diff_ff <= $signed({1'b0, log_p}) - $signed({1'b0, log_q});

         p_m1_ff <= p_df_ff;
         prod_ln_ff <= diff_ff * kld_pkg::LN2_Q16;

         p_ln_ff <= p_m1_ff;
         ln_ff <= ln_round[21:0];

         prod_term_ff <= $signed({1'b0, p_ln_ff}) * ln_ff;

         term_ff <= term_round[21:0];

         fin_sum_ff <= fin_sum_in;
         fin_err_ff <= err_next;

         rsp_divergence_ff <= rsp_divergence_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

endmodule

`default_nettype wire
